/* sv/tsa_pkg.sv */
// ============================================================================
// tsa_pkg - shared types and constants for the touch sample average/scale block
// Widths of the sample, register and arithmetic paths, the register map, the
// structures that pass between the front end, the job queue and the back end.
// ============================================================================
package tsa_pkg;

    // Samples per axis and field widths.
    localparam int SAMPLES    = 5;
    localparam int SAMPLE_W   = 12;
    localparam int REG_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int SUM_W      = 15;   // 5 * 4095 fits in 15 bits
    localparam int CNT_W      = 3;    // 0 .. 5 samples in window
    localparam int DIFF_W     = 15;   // sum - count * low, at most 5 * 4095
    localparam int DEN_W      = 16;   // count * (high - low), at most 5 * 8191
    localparam int NUM_W      = DIFF_W + REG_W;
    localparam int QUO_W      = REG_W; // quotient never exceeds the range register
    localparam int QUO_IDX_W  = $clog2(QUO_W);
    localparam int DIV_STAGES = QUO_W;

    // Queue between front end and back end.
    localparam int MID_DEPTH  = 4;
    localparam int MID_PTR_W  = $clog2(MID_DEPTH);
    localparam int MID_CNT_W  = MID_PTR_W + 1;

    // Result queue in the back end; its depth also sets the credit limit.
    localparam int OUT_DEPTH  = 16;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = OUT_PTR_W + 1;

    // Register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAW_X_LOW     = 3'd0,
        REG_RAW_X_HIGH    = 3'd1,
        REG_RAW_Y_LOW     = 3'd2,
        REG_RAW_Y_HIGH    = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5
    } cfg_index_e;

    localparam logic [REG_W-1:0] RST_RAW_X_LOW     = 13'd0;
    localparam logic [REG_W-1:0] RST_RAW_X_HIGH    = 13'd4095;
    localparam logic [REG_W-1:0] RST_RAW_Y_LOW     = 13'd0;
    localparam logic [REG_W-1:0] RST_RAW_Y_HIGH    = 13'd4095;
    localparam logic [REG_W-1:0] RST_SCREEN_WIDTH  = 13'd320;
    localparam logic [REG_W-1:0] RST_SCREEN_HEIGHT = 13'd240;

    typedef logic [SAMPLES-1:0][SAMPLE_W-1:0] samples_t;

    typedef struct packed {
        logic [REG_W-1:0] raw_x_low;
        logic [REG_W-1:0] raw_x_high;
        logic [REG_W-1:0] raw_y_low;
        logic [REG_W-1:0] raw_y_high;
        logic [REG_W-1:0] screen_width;
        logic [REG_W-1:0] screen_height;
    } cfg_t;

    // One axis of a classified read. zero forces the coordinate to 0.
    typedef struct packed {
        logic              zero;
        logic [DIFF_W-1:0] diff;
        logic [DEN_W-1:0]  den;
    } job_lane_t;

    typedef struct packed {
        logic      touch;
        job_lane_t x;
        job_lane_t y;
    } job_t;

    // One axis inside the divider pipeline.
    typedef struct packed {
        logic             zero;
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic      touch;
        div_lane_t x;
        div_lane_t y;
    } div_stage_t;

    typedef struct packed {
        logic             touch_down;
        logic [REG_W-1:0] pos_x;
        logic [REG_W-1:0] pos_y;
    } result_t;

    // Small count (0..7) times a 13-bit value, as shift and add.
    function automatic logic [DEN_W-1:0] mul_cnt(input logic [CNT_W-1:0] c,
                                                 input logic [REG_W-1:0] v);
        logic [DEN_W-1:0] w;
        logic [DEN_W-1:0] acc;
        w   = DEN_W'(v);
        acc = '0;
        if (c[0]) acc = acc + w;
        if (c[1]) acc = acc + (w << 1);
        if (c[2]) acc = acc + (w << 2);
        return acc;
    endfunction

endpackage

/* sv/tsa_front.sv */
// ============================================================================
// tsa_front - window filter, sum and count for each touch read
// Two registered stages: the first filters and accumulates the samples of each
// axis, the second forms the numerator offset and the denominator per axis.
// ============================================================================
module tsa_front (
    input  logic              clk,
    input  logic              rst_n,
    input  tsa_pkg::cfg_t     cfg,
    input  logic              in_push,
    output logic              in_full,
    input  logic              pen_up,
    input  tsa_pkg::samples_t x_samples,
    input  tsa_pkg::samples_t y_samples,
    output logic              q_push,
    input  logic              q_full,
    output tsa_pkg::job_t     q_job
);

    logic f1_valid_reg;
    logic f2_valid_reg;
    logic f1_ready;
    logic f2_ready;
    logic in_fire;

    logic                        f1_pen_reg;
    logic [tsa_pkg::SUM_W-1:0]   f1_sum_x_reg;
    logic [tsa_pkg::SUM_W-1:0]   f1_sum_y_reg;
    logic [tsa_pkg::CNT_W-1:0]   f1_cnt_x_reg;
    logic [tsa_pkg::CNT_W-1:0]   f1_cnt_y_reg;
    logic [tsa_pkg::SUM_W-1:0]   sum_x_next;
    logic [tsa_pkg::SUM_W-1:0]   sum_y_next;
    logic [tsa_pkg::CNT_W-1:0]   cnt_x_next;
    logic [tsa_pkg::CNT_W-1:0]   cnt_y_next;

    tsa_pkg::job_t f2_job_reg;
    tsa_pkg::job_t job_next;

    // A stage may load when it is empty or its content moves on this cycle.
    assign f2_ready = !f2_valid_reg || !q_full;
    assign f1_ready = !f1_valid_reg || f2_ready;
    assign in_full  = !f1_ready;
    assign in_fire  = in_push && f1_ready;
    assign q_push   = f2_valid_reg;
    assign q_job    = f2_job_reg;

    always_comb
    begin
        sum_x_next = '0;
        sum_y_next = '0;
        cnt_x_next = '0;
        cnt_y_next = '0;
        for (int i = 0; i < tsa_pkg::SAMPLES; i++)
        begin
            if (tsa_pkg::REG_W'(x_samples[i]) >= cfg.raw_x_low &&
                tsa_pkg::REG_W'(x_samples[i]) <= cfg.raw_x_high)
            begin
                sum_x_next = sum_x_next + tsa_pkg::SUM_W'(x_samples[i]);
                cnt_x_next = cnt_x_next + tsa_pkg::CNT_W'(1);
            end
            if (tsa_pkg::REG_W'(y_samples[i]) >= cfg.raw_y_low &&
                tsa_pkg::REG_W'(y_samples[i]) <= cfg.raw_y_high)
            begin
                sum_y_next = sum_y_next + tsa_pkg::SUM_W'(y_samples[i]);
                cnt_y_next = cnt_y_next + tsa_pkg::CNT_W'(1);
            end
        end
    end

    // Every accepted sample is at least the low bound, so the offset sum
    // never goes negative when the axis has samples.
    always_comb
    begin
        logic [tsa_pkg::DEN_W-1:0] off_x;
        logic [tsa_pkg::DEN_W-1:0] off_y;
        off_x = tsa_pkg::DEN_W'(f1_sum_x_reg) - tsa_pkg::mul_cnt(f1_cnt_x_reg, cfg.raw_x_low);
        off_y = tsa_pkg::DEN_W'(f1_sum_y_reg) - tsa_pkg::mul_cnt(f1_cnt_y_reg, cfg.raw_y_low);
        job_next.touch  = !f1_pen_reg && (f1_cnt_x_reg != '0) && (f1_cnt_y_reg != '0);
        job_next.x.zero = !job_next.touch || (cfg.raw_x_high <= cfg.raw_x_low);
        job_next.y.zero = !job_next.touch || (cfg.raw_y_high <= cfg.raw_y_low);
        job_next.x.diff = off_x[tsa_pkg::DIFF_W-1:0];
        job_next.y.diff = off_y[tsa_pkg::DIFF_W-1:0];
        job_next.x.den  = tsa_pkg::mul_cnt(f1_cnt_x_reg, cfg.raw_x_high - cfg.raw_x_low);
        job_next.y.den  = tsa_pkg::mul_cnt(f1_cnt_y_reg, cfg.raw_y_high - cfg.raw_y_low);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            if (f1_ready)
            begin
                f1_valid_reg <= in_fire;
            end
            if (f2_ready)
            begin
                f2_valid_reg <= f1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            f1_pen_reg   <= pen_up;
            f1_sum_x_reg <= sum_x_next;
            f1_sum_y_reg <= sum_y_next;
            f1_cnt_x_reg <= cnt_x_next;
            f1_cnt_y_reg <= cnt_y_next;
        end
        if (f2_ready && f1_valid_reg)
        begin
            f2_job_reg <= job_next;
        end
    end

endmodule

/* sv/tsa_job_queue.sv */
// ============================================================================
// tsa_job_queue - short queue of classified reads
// Four entries between the front end and the back end so that either side can
// stall without stopping the other.
// ============================================================================
module tsa_job_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tsa_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output tsa_pkg::job_t pop_job,
    output logic          empty
);

    tsa_pkg::job_t                  mem_reg [tsa_pkg::MID_DEPTH];
    logic [tsa_pkg::MID_PTR_W-1:0]  wr_ptr_reg;
    logic [tsa_pkg::MID_PTR_W-1:0]  rd_ptr_reg;
    logic [tsa_pkg::MID_CNT_W-1:0]  count_reg;
    logic                           push_fire;
    logic                           pop_fire;

    assign full      = (count_reg == tsa_pkg::MID_CNT_W'(tsa_pkg::MID_DEPTH));
    assign empty     = (count_reg == '0);
    assign push_fire = push && !full;
    assign pop_fire  = pop && !empty;
    assign pop_job   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + tsa_pkg::MID_PTR_W'(1);
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + tsa_pkg::MID_PTR_W'(1);
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + tsa_pkg::MID_CNT_W'(1);
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - tsa_pkg::MID_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* sv/tsa_back.sv */
// ============================================================================
// tsa_back - scaling multiply, pipelined divider and result queue
// One multiply stage, then one restoring divide stage per quotient bit for
// both axes in parallel, then a result queue. Jobs enter only while the
// queue has a free slot for every job already in flight.
// ============================================================================
module tsa_back (
    input  logic             clk,
    input  logic             rst_n,
    input  tsa_pkg::cfg_t    cfg,
    input  logic             q_empty,
    input  tsa_pkg::job_t    q_job,
    output logic             q_pop,
    input  logic             out_pop,
    output logic             out_empty,
    output tsa_pkg::result_t out_result
);

    localparam int LAST = tsa_pkg::DIV_STAGES;

    logic                        valid_reg [0:LAST];
    tsa_pkg::div_stage_t         stage_reg [0:LAST];
    tsa_pkg::div_stage_t         stage_next [1:LAST];
    tsa_pkg::div_stage_t         mul_next;

    tsa_pkg::result_t                out_mem_reg [tsa_pkg::OUT_DEPTH];
    logic [tsa_pkg::OUT_PTR_W-1:0]   out_wr_ptr_reg;
    logic [tsa_pkg::OUT_PTR_W-1:0]   out_rd_ptr_reg;
    logic [tsa_pkg::OUT_CNT_W-1:0]   out_count_reg;
    logic [tsa_pkg::OUT_CNT_W-1:0]   back_count_reg;
    logic                            issue;
    logic                            pop_fire;
    logic                            out_push;
    tsa_pkg::result_t                result_next;

    function automatic tsa_pkg::div_lane_t div_step(input tsa_pkg::div_lane_t l,
                                                    input logic [tsa_pkg::QUO_IDX_W-1:0] k);
        logic [tsa_pkg::NUM_W:0] sub;
        logic [tsa_pkg::NUM_W:0] trial;
        tsa_pkg::div_lane_t      r;
        r     = l;
        sub   = (tsa_pkg::NUM_W+1)'(l.den) << k;
        trial = {1'b0, l.rem} - sub;
        if (!trial[tsa_pkg::NUM_W])
        begin
            r.rem    = trial[tsa_pkg::NUM_W-1:0];
            r.quo[k] = 1'b1;
        end
        return r;
    endfunction

    // back_count_reg counts jobs in the pipeline plus results in the queue.
    assign issue     = !q_empty && (back_count_reg < tsa_pkg::OUT_CNT_W'(tsa_pkg::OUT_DEPTH));
    assign q_pop     = issue;
    assign out_empty = (out_count_reg == '0);
    assign pop_fire  = out_pop && !out_empty;
    assign out_result = out_mem_reg[out_rd_ptr_reg];
    assign out_push  = valid_reg[LAST];

    always_comb
    begin
        mul_next.touch  = q_job.touch;
        mul_next.x.zero = q_job.x.zero;
        mul_next.x.rem  = tsa_pkg::NUM_W'(q_job.x.diff) * tsa_pkg::NUM_W'(cfg.screen_width);
        mul_next.x.den  = q_job.x.den;
        mul_next.x.quo  = '0;
        mul_next.y.zero = q_job.y.zero;
        mul_next.y.rem  = tsa_pkg::NUM_W'(q_job.y.diff) * tsa_pkg::NUM_W'(cfg.screen_height);
        mul_next.y.den  = q_job.y.den;
        mul_next.y.quo  = '0;
    end

    // Stage s settles quotient bit LAST - s, most significant first.
    for (genvar s = 1; s <= LAST; s++)
    begin : g_div
        localparam logic [tsa_pkg::QUO_IDX_W-1:0] K = tsa_pkg::QUO_IDX_W'(LAST - s);
        always_comb
        begin
            stage_next[s].touch = stage_reg[s-1].touch;
            stage_next[s].x     = div_step(stage_reg[s-1].x, K);
            stage_next[s].y     = div_step(stage_reg[s-1].y, K);
        end
    end

    always_comb
    begin
        result_next.touch_down = stage_reg[LAST].touch;
        result_next.pos_x      = stage_reg[LAST].x.zero ? '0 : stage_reg[LAST].x.quo;
        result_next.pos_y      = stage_reg[LAST].y.zero ? '0 : stage_reg[LAST].y.quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= LAST; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
            back_count_reg <= '0;
        end
        else
        begin
            valid_reg[0] <= issue;
            for (int s = 1; s <= LAST; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
            if (out_push)
            begin
                out_wr_ptr_reg <= out_wr_ptr_reg + tsa_pkg::OUT_PTR_W'(1);
            end
            if (pop_fire)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + tsa_pkg::OUT_PTR_W'(1);
            end
            if (out_push && !pop_fire)
            begin
                out_count_reg <= out_count_reg + tsa_pkg::OUT_CNT_W'(1);
            end
            else if (pop_fire && !out_push)
            begin
                out_count_reg <= out_count_reg - tsa_pkg::OUT_CNT_W'(1);
            end
            if (issue && !pop_fire)
            begin
                back_count_reg <= back_count_reg + tsa_pkg::OUT_CNT_W'(1);
            end
            else if (pop_fire && !issue)
            begin
                back_count_reg <= back_count_reg - tsa_pkg::OUT_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg[0] <= mul_next;
        for (int s = 1; s <= LAST; s++)
        begin
            stage_reg[s] <= stage_next[s];
        end
        if (out_push)
        begin
            out_mem_reg[out_wr_ptr_reg] <= result_next;
        end
    end

    // The credit scheme must keep the result queue from overflowing.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_count_reg != tsa_pkg::OUT_CNT_W'(tsa_pkg::OUT_DEPTH)))
        else $error("result queue written while full");

    a_credit_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
        back_count_reg >= out_count_reg)
        else $error("credit count below result queue occupancy");

    a_no_touch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_empty && !out_result.touch_down) |->
            (out_result.pos_x == '0 && out_result.pos_y == '0))
        else $error("no-touch result carries a nonzero coordinate");

endmodule

/* sv/touch_sample_average_scale.sv */
// ============================================================================
// touch_sample_average_scale - oversampled touch read averaging and scaling
// Filters five X and five Y samples against raw windows, averages the rest
// and maps the average onto the screen range.
// ============================================================================
// Usage:
//   Reads enter through a queue-style port: a transfer happens at a clock
//   edge with push high and full low. Each read carries pen_up and five raw
//   samples per axis. Results leave the same way: while empty is low the
//   oldest result is on touch_down, pos_x and pos_y, and a transfer happens
//   at an edge with pop high. Every read yields exactly one result, in order.
//   Registers are written through cfg_valid/cfg_ready (cfg_ready is always
//   high) with cfg_index selecting the register; indexes above five are
//   ignored. Write them only while no read is in flight.
//   The block takes one read per cycle while the receiver keeps popping;
//   that rate is set by the 13-stage divider, which starts one job per cycle,
//   and its credit loop of 16 result slots. When the receiver stops popping,
//   results collect in the 16-entry result queue, then the 4-entry job queue
//   and the two front stages fill and full rises; nothing is lost and the
//   pipeline resumes when pop returns.
//   Reset clears all queues and loads the registers with their defaults
//   (window 0..4095 on both axes, screen 320 by 240).
// ============================================================================
module touch_sample_average_scale (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsa_pkg::REG_W-1:0]       cfg_data,
    // read input
    input  logic                            push,
    output logic                            full,
    input  logic                            pen_up,
    input  logic [tsa_pkg::SAMPLE_W-1:0]    x_sample_0,
    input  logic [tsa_pkg::SAMPLE_W-1:0]    x_sample_1,
    input  logic [tsa_pkg::SAMPLE_W-1:0]    x_sample_2,
    input  logic [tsa_pkg::SAMPLE_W-1:0]    x_sample_3,
    input  logic [tsa_pkg::SAMPLE_W-1:0]    x_sample_4,
    input  logic [tsa_pkg::SAMPLE_W-1:0]    y_sample_0,
    input  logic [tsa_pkg::SAMPLE_W-1:0]    y_sample_1,
    input  logic [tsa_pkg::SAMPLE_W-1:0]    y_sample_2,
    input  logic [tsa_pkg::SAMPLE_W-1:0]    y_sample_3,
    input  logic [tsa_pkg::SAMPLE_W-1:0]    y_sample_4,
    // result output
    output logic                            empty,
    input  logic                            pop,
    output logic                            touch_down,
    output logic [tsa_pkg::REG_W-1:0]       pos_x,
    output logic [tsa_pkg::REG_W-1:0]       pos_y
);

    tsa_pkg::cfg_t     cfg_reg;
    tsa_pkg::samples_t x_samples;
    tsa_pkg::samples_t y_samples;
    tsa_pkg::job_t     front_job;
    tsa_pkg::job_t     queue_job;
    tsa_pkg::result_t  result;
    logic              front_push;
    logic              queue_full;
    logic              queue_empty;
    logic              queue_pop;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raw_x_low     <= tsa_pkg::RST_RAW_X_LOW;
            cfg_reg.raw_x_high    <= tsa_pkg::RST_RAW_X_HIGH;
            cfg_reg.raw_y_low     <= tsa_pkg::RST_RAW_Y_LOW;
            cfg_reg.raw_y_high    <= tsa_pkg::RST_RAW_Y_HIGH;
            cfg_reg.screen_width  <= tsa_pkg::RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= tsa_pkg::RST_SCREEN_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tsa_pkg::cfg_index_e'(cfg_index))
                tsa_pkg::REG_RAW_X_LOW:     cfg_reg.raw_x_low     <= cfg_data;
                tsa_pkg::REG_RAW_X_HIGH:    cfg_reg.raw_x_high    <= cfg_data;
                tsa_pkg::REG_RAW_Y_LOW:     cfg_reg.raw_y_low     <= cfg_data;
                tsa_pkg::REG_RAW_Y_HIGH:    cfg_reg.raw_y_high    <= cfg_data;
                tsa_pkg::REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data;
                tsa_pkg::REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data;
                default:
                begin
                    // Unmapped index: the write is dropped.
                end
            endcase
        end
    end

    assign x_samples = {x_sample_4, x_sample_3, x_sample_2, x_sample_1, x_sample_0};
    assign y_samples = {y_sample_4, y_sample_3, y_sample_2, y_sample_1, y_sample_0};

    // Front end: window filter, sums and counts, numerator offset and divisor.
    tsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_push   (push),
        .in_full   (full),
        .pen_up    (pen_up),
        .x_samples (x_samples),
        .y_samples (y_samples),
        .q_push    (front_push),
        .q_full    (queue_full),
        .q_job     (front_job)
    );

    // Decoupling queue between the two halves.
    tsa_job_queue u_job_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_job (front_job),
        .full     (queue_full),
        .pop      (queue_pop),
        .pop_job  (queue_job),
        .empty    (queue_empty)
    );

    // Back end: scale multiply, divider pipeline and result queue.
    tsa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (queue_empty),
        .q_job      (queue_job),
        .q_pop      (queue_pop),
        .out_pop    (pop),
        .out_empty  (empty),
        .out_result (result)
    );

    assign touch_down = result.touch_down;
    assign pos_x      = result.pos_x;
    assign pos_y      = result.pos_y;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top - testbench for touch_sample_average_scale
// Sends touch reads through the push/full port and checks each popped point
// against a local predictor of the windowed average and linear scaling. Runs
// directed corner cases, then randomized register settings and reads, with
// random idle cycles on both sides, a stretch with no idling and a phase that
// holds off pop until the block signals full.
// ============================================================================
module tb_top;
    import tsa_pkg::*;

    // Accepted read latency in edges; the tail wait after the last drain is based on it.
    localparam int LATENCY     = 18;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 8;

    // One touch read as the predictor sees it.
    typedef struct packed {
        logic     pen_up;
        samples_t x;
        samples_t y;
    } touch_read_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 pen_up = 1'b0;
    logic [SAMPLE_W-1:0]  x_sample_0 = '0;
    logic [SAMPLE_W-1:0]  x_sample_1 = '0;
    logic [SAMPLE_W-1:0]  x_sample_2 = '0;
    logic [SAMPLE_W-1:0]  x_sample_3 = '0;
    logic [SAMPLE_W-1:0]  x_sample_4 = '0;
    logic [SAMPLE_W-1:0]  y_sample_0 = '0;
    logic [SAMPLE_W-1:0]  y_sample_1 = '0;
    logic [SAMPLE_W-1:0]  y_sample_2 = '0;
    logic [SAMPLE_W-1:0]  y_sample_3 = '0;
    logic [SAMPLE_W-1:0]  y_sample_4 = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic                 touch_down;
    logic [REG_W-1:0]     pos_x;
    logic [REG_W-1:0]     pos_y;

    // Shadow copy of the block's registers, updated on each register transfer.
    cfg_t    shadow_regs;
    // Points predicted for accepted reads, oldest first.
    result_t pending_points[$];
    int      failures = 0;
    int      cycles = 0;
    // Stimulus mode flags, changed only with nonblocking assignments so that
    // the pop driver sees a stable value at each falling edge.
    logic    no_idle = 1'b0;
    logic    pop_hold = 1'b0;

    touch_sample_average_scale i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .pen_up     (pen_up),
        .x_sample_0 (x_sample_0),
        .x_sample_1 (x_sample_1),
        .x_sample_2 (x_sample_2),
        .x_sample_3 (x_sample_3),
        .x_sample_4 (x_sample_4),
        .y_sample_0 (y_sample_0),
        .y_sample_1 (y_sample_1),
        .y_sample_2 (y_sample_2),
        .y_sample_3 (y_sample_3),
        .y_sample_4 (y_sample_4),
        .empty      (empty),
        .pop        (pop),
        .touch_down (touch_down),
        .pos_x      (pos_x),
        .pos_y      (pos_y)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Averages the samples of one axis that fall inside [lo, hi] and maps the
    // average onto 0..span. Returns 0 when no sample is inside the window. A
    // window whose upper bound is not above the lower one gives coordinate 0.
    function automatic logic average_axis(input samples_t s, input logic [REG_W-1:0] lo,
                                          input logic [REG_W-1:0] hi,
                                          input logic [REG_W-1:0] span,
                                          output logic [REG_W-1:0] coord);
        int unsigned       sum;
        int unsigned       hits;
        longint unsigned   offset_sum;
        longint unsigned   num;
        longint unsigned   den;
        sum   = 0;
        hits  = 0;
        coord = '0;
        for (int i = 0; i < SAMPLES; i++)
        begin
            if (s[i] >= lo && s[i] <= hi)
            begin
                sum  += s[i];
                hits += 1;
            end
        end
        if (hits == 0)
            return 1'b0;
        if (hi <= lo)
            return 1'b1;
        // Every accepted sample is at least lo, so the offset sum is not negative.
        offset_sum = sum - hits * lo;
        num        = offset_sum * span;
        den        = hits * (hi - lo);
        coord      = REG_W'(num / den);
        return 1'b1;
    endfunction

    // Expected point for one read under the given register values.
    function automatic result_t predict_point(input touch_read_t rd, input cfg_t regs);
        result_t          point;
        logic             x_ok;
        logic             y_ok;
        logic [REG_W-1:0] px;
        logic [REG_W-1:0] py;
        point = '0;
        if (rd.pen_up)
            return point;
        x_ok = average_axis(rd.x, regs.raw_x_low, regs.raw_x_high, regs.screen_width, px);
        y_ok = average_axis(rd.y, regs.raw_y_low, regs.raw_y_high, regs.screen_height, py);
        if (x_ok && y_ok)
        begin
            point.touch_down = 1'b1;
            point.pos_x      = px;
            point.pos_y      = py;
        end
        return point;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor and checker. Register transfers, read transfers and result
    // transfers are all observed in this one process, so the order in which
    // the prediction queue is filled and drained within a step is fixed.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        touch_read_t rd;
        result_t     want;
        if (!rst_n)
        begin
            shadow_regs = '{raw_x_low:     RST_RAW_X_LOW,
                            raw_x_high:    RST_RAW_X_HIGH,
                            raw_y_low:     RST_RAW_Y_LOW,
                            raw_y_high:    RST_RAW_Y_HIGH,
                            screen_width:  RST_SCREEN_WIDTH,
                            screen_height: RST_SCREEN_HEIGHT};
            pending_points.delete();
        end
        else
        begin
            // A popped point must match the oldest prediction field by field.
            if (pop && !empty)
            begin
                if (pending_points.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: point with no read waiting: touch %0b x %0d y %0d",
                                 $realtime, touch_down, pos_x, pos_y);
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (touch_down !== want.touch_down || pos_x !== want.pos_x
                        || pos_y !== want.pos_y)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("%0t: expected touch %0b x %0d y %0d, got touch %0b x %0d y %0d",
                                     $realtime, want.touch_down, want.pos_x, want.pos_y,
                                     touch_down, pos_x, pos_y);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_e'(cfg_index))
                    REG_RAW_X_LOW:     shadow_regs.raw_x_low     = cfg_data;
                    REG_RAW_X_HIGH:    shadow_regs.raw_x_high    = cfg_data;
                    REG_RAW_Y_LOW:     shadow_regs.raw_y_low     = cfg_data;
                    REG_RAW_Y_HIGH:    shadow_regs.raw_y_high    = cfg_data;
                    REG_SCREEN_WIDTH:  shadow_regs.screen_width  = cfg_data;
                    REG_SCREEN_HEIGHT: shadow_regs.screen_height = cfg_data;
                    default: ;
                endcase
            end

            if (push && !full)
            begin
                rd.pen_up = pen_up;
                rd.x      = {x_sample_4, x_sample_3, x_sample_2, x_sample_1, x_sample_0};
                rd.y      = {y_sample_4, y_sample_3, y_sample_2, y_sample_1, y_sample_0};
                pending_points.push_back(predict_point(rd, shadow_regs));
            end
        end
    end

    // The receiver idles at random, except during the no-idle stretch, and
    // holds off completely while the backpressure test asks it to.
    always @(negedge clk)
    begin
        pop <= !pop_hold && (no_idle || $urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: a run that cannot finish is a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("touch_sample_average_scale: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Sends one read: random idle cycles first, then push held high until the
    // transfer happens at an edge where full is low.
    task automatic send_read(input touch_read_t rd);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        pen_up     <= rd.pen_up;
        x_sample_0 <= rd.x[0];
        x_sample_1 <= rd.x[1];
        x_sample_2 <= rd.x[2];
        x_sample_3 <= rd.x[3];
        x_sample_4 <= rd.x[4];
        y_sample_0 <= rd.y[0];
        y_sample_1 <= rd.y[1];
        y_sample_2 <= rd.y[2];
        y_sample_3 <= rd.y[3];
        y_sample_4 <= rd.y[4];
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Stops pushing and waits until every predicted point has been popped.
    // Every read yields a point, so the block is idle at that moment.
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_e idx, input logic [REG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Writes all six registers once the block has drained.
    task automatic set_registers(input cfg_t regs);
        wait_idle();
        write_reg(REG_RAW_X_LOW,     regs.raw_x_low);
        write_reg(REG_RAW_X_HIGH,    regs.raw_x_high);
        write_reg(REG_RAW_Y_LOW,     regs.raw_y_low);
        write_reg(REG_RAW_Y_HIGH,    regs.raw_y_high);
        write_reg(REG_SCREEN_WIDTH,  regs.screen_width);
        write_reg(REG_SCREEN_HEIGHT, regs.screen_height);
    endtask

    function automatic touch_read_t read_of(input logic pen, input samples_t xs,
                                            input samples_t ys);
        touch_read_t rd;
        rd.pen_up = pen;
        rd.x      = xs;
        rd.y      = ys;
        return rd;
    endfunction

    // Lower bound of a raw window: mostly inside the converter range, with
    // the edges and values above 4095 (which accept nothing) now and then.
    function automatic logic [REG_W-1:0] random_low();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 15)
            return REG_W'(4095);
        if (roll < 18)
            return REG_W'($urandom_range(8191, 4096));
        return REG_W'($urandom_range(4095, 0));
    endfunction

    // Upper bound: mostly at or above lo, sometimes equal to it or below it.
    function automatic logic [REG_W-1:0] random_high(input logic [REG_W-1:0] lo);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return REG_W'(8191);
        if (roll < 15)
            return lo;
        if (roll < 20)
            return REG_W'(4095);
        if (roll < 23)
            return REG_W'($urandom_range(lo, 0));
        if (lo > 4095)
            return REG_W'(8191);
        return REG_W'($urandom_range(4095, lo));
    endfunction

    function automatic logic [REG_W-1:0] random_span();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return REG_W'(8191);
        if (roll < 30)
            return REG_W'(4096);
        return REG_W'($urandom_range(2000, 1));
    endfunction

    function automatic cfg_t random_regs();
        cfg_t regs;
        regs.raw_x_low     = random_low();
        regs.raw_x_high    = random_high(regs.raw_x_low);
        regs.raw_y_low     = random_low();
        regs.raw_y_high    = random_high(regs.raw_y_low);
        regs.screen_width  = random_span();
        regs.screen_height = random_span();
        return regs;
    endfunction

    // One raw sample. Most land inside the window so that averages over
    // several samples are exercised; the rest are edges, rails and noise.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [REG_W-1:0] lo,
                                                        input logic [REG_W-1:0] hi);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return '0;
        if (roll < 12)
            return '1;
        if (roll < 18 && lo <= 4095)
            return SAMPLE_W'(lo);
        if (roll < 24 && hi <= 4095)
            return SAMPLE_W'(hi);
        if (roll < 85 && lo <= hi && lo <= 4095)
            return SAMPLE_W'($urandom_range((hi > 4095) ? 4095 : hi, lo));
        return SAMPLE_W'($urandom_range(4095, 0));
    endfunction

    function automatic touch_read_t random_read(input cfg_t regs);
        touch_read_t rd;
        rd.pen_up = ($urandom_range(99) < 10);
        for (int i = 0; i < SAMPLES; i++)
        begin
            rd.x[i] = pick_sample(regs.raw_x_low, regs.raw_x_high);
            rd.y[i] = pick_sample(regs.raw_y_low, regs.raw_y_high);
        end
        return rd;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values of the registers: pen up, rails and alternating bit patterns.
    task automatic test_reset_defaults();
        send_read(read_of(1'b1, {5{12'hFFF}}, {5{12'hFFF}}));
        send_read(read_of(1'b0, '0, '0));
        send_read(read_of(1'b0, {5{12'hFFF}}, {5{12'hFFF}}));
        send_read(read_of(1'b0, {12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA},
                                {12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555}));
        send_read(read_of(1'b1, '0, '0));
    endtask

    // Proper windows: all in, one axis empty, the other empty, and samples
    // exactly on the window edges mixed with samples just outside.
    task automatic test_window_cases();
        set_registers('{13'd1000, 13'd3000, 13'd500, 13'd3500, 13'd8191, 13'd4096});
        send_read(read_of(1'b0, {12'd1000, 12'd3000, 12'd2000, 12'd1500, 12'd2500},
                                {12'd500, 12'd3500, 12'd600, 12'd700, 12'd800}));
        send_read(read_of(1'b0, {12'd999, 12'd3001, 12'd0, 12'd4095, 12'd12},
                                {12'd1000, 12'd2000, 12'd3000, 12'd3400, 12'd501}));
        send_read(read_of(1'b0, {12'd1001, 12'd1002, 12'd2999, 12'd1500, 12'd2000},
                                {12'd499, 12'd3501, 12'd0, 12'd4095, 12'd4000}));
        send_read(read_of(1'b0, {12'd999, 12'd1000, 12'd3000, 12'd3001, 12'd2222},
                                {12'd0, 12'd500, 12'd4095, 12'd3500, 12'd1234}));
    endtask

    // Windows of a single value, lower bounds above the converter range,
    // inverted windows, zero and full-scale ranges, single accepted samples.
    task automatic test_degenerate_windows();
        set_registers('{13'd2048, 13'd2048, 13'd0, 13'd8191, 13'd4095, 13'd0});
        send_read(read_of(1'b0, {12'd2048, 12'd2048, 12'd1, 12'd2048, 12'd4095},
                                {12'd17, 12'd4095, 12'd0, 12'd2500, 12'd300}));
        send_read(read_of(1'b0, {12'd2047, 12'd2049, 12'd0, 12'd4095, 12'd100},
                                {12'd1, 12'd2, 12'd3, 12'd4, 12'd5}));

        set_registers('{13'd4096, 13'd8191, 13'd0, 13'd4096, 13'd8191, 13'd8191});
        send_read(read_of(1'b0, {5{12'hFFF}}, {5{12'd2000}}));

        set_registers('{13'd0, 13'd8191, 13'd3000, 13'd1000, 13'd8191, 13'd8191});
        send_read(read_of(1'b0, {5{12'hFFF}},
                                {12'd3000, 12'd1000, 12'd2000, 12'd0, 12'd4095}));

        set_registers('{13'd0, 13'd1, 13'd4094, 13'd4095, 13'd8191, 13'd8191});
        send_read(read_of(1'b0, {12'd1, 12'd1, 12'd0, 12'd1, 12'd0},
                                {12'd4095, 12'd4094, 12'd4095, 12'd4095, 12'd4094}));
        send_read(read_of(1'b0, {12'd0, 12'd5, 12'd6, 12'd7, 12'd8},
                                {12'd4095, 12'd0, 12'd0, 12'd0, 12'd0}));
    endtask

    // Several random register settings, each followed by random reads.
    task automatic test_random_settings();
        cfg_t regs;
        for (int phase = 0; phase < 7; phase++)
        begin
            regs = random_regs();
            set_registers(regs);
            repeat (250)
                send_read(random_read(regs));
        end
    endtask

    // Back-to-back transfers on both sides: one read and one point per cycle.
    task automatic test_no_idle_stretch();
        cfg_t regs;
        regs = '{13'd200, 13'd3900, 13'd150, 13'd3950, 13'd1024, 13'd768};
        set_registers(regs);
        @(negedge clk);
        no_idle <= 1'b1;
        repeat (200)
            send_read(random_read(regs));
        wait_idle();
        no_idle <= 1'b0;
    endtask

    // Holds pop low until the block raises full, then lets the queues drain.
    // Every read sent while stalled must still come out, in order.
    task automatic test_result_backpressure();
        cfg_t regs;
        regs = random_regs();
        set_registers(regs);
        @(negedge clk);
        pop_hold <= 1'b1;
        fork
            begin
                repeat (60)
                    send_read(random_read(regs));
            end
            begin
                @(negedge clk);
                while (!full)
                    @(negedge clk);
                pop_hold <= 1'b0;
            end
        join
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Reset is held and then released on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_window_cases();
        test_degenerate_windows();
        test_random_settings();
        test_no_idle_stretch();
        test_result_backpressure();

        // Drain, then leave room for any point the block should not produce.
        wait_idle();
        repeat (2 * LATENCY) @(posedge clk);
        if (failures == 0 && pending_points.size() == 0)
            $display("touch_sample_average_scale: match");
        else
            $display("touch_sample_average_scale: mismatch");
        $finish;
    end

endmodule
